@@ hdl/lz78_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lz78_pkg;

  localparam int unsigned PHRASE_W = 12;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned NFI_W = 13;
  localparam int unsigned ENTRY_W = PHRASE_W + SYM_W;

  localparam int unsigned DICT_ENTRIES_DEF = 4096;
  localparam int unsigned MAX_INDEX = 4095;
  localparam logic [PHRASE_W-1:0] LIMIT_RESET = 12'd4095;

  localparam logic [31:0] HASH_MUL = 32'h9E37_79B1;

endpackage

`default_nettype wire

@@ hdl/lz78_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lz78_in_if;
  logic                          valid;
  logic                          ready;
  logic [lz78_pkg::SYM_W-1:0]    symbol_byte;
  logic                          is_final;

  modport source (output valid, output symbol_byte, output is_final, input ready);
  modport sink (input valid, input symbol_byte, input is_final, output ready);
endinterface

interface lz78_out_if;
  logic                          valid;
  logic                          ready;
  logic [lz78_pkg::PHRASE_W-1:0] phrase_index;
  logic [lz78_pkg::SYM_W-1:0]    next_symbol;
  logic                          has_symbol;
  logic                          end_of_message;

  modport source (
    output valid, output phrase_index, output next_symbol, output has_symbol,
    output end_of_message, input ready
  );
  modport sink (
    input valid, input phrase_index, input next_symbol, input has_symbol,
    input end_of_message, output ready
  );
endinterface

`default_nettype wire

@@ hdl/lz78_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// LZ78 encoder. Each request carries one message byte; a token is produced
// on a dictionary miss and on the final byte of a message. The phrase
// dictionary sits in a synchronous memory indexed by phrase number, and a
// second memory of twice that many slots maps the hashed pair of prefix and
// byte to a phrase number by linear probing. Each phrase also records the
// slot that points to it, so a slot left over from an earlier message is
// seen as free. An accepted byte is hashed and its slot is read from the
// hash memory; if the slot is in use, the entry it points to is then read
// from the dictionary, and each further probe reads another slot and its
// entry. Both memories have registered reads. A byte that needs a token
// also waits while the previous token is still held in the output
// register. After reset the hash memory is cleared one slot a cycle, and
// no request is accepted until every slot is clear. The dictionary is
// emptied at the end of each message. A token waiting in the output
// register does not stop the next byte from being accepted.
module lz78_encoder #(
  parameter int unsigned DICT_ENTRIES = lz78_pkg::DICT_ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lz78_in_if.sink                            req_i,
  lz78_out_if.source                         tok_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lz78_pkg::PHRASE_W-1:0] cfg_wdata_i
);

  localparam int unsigned DICT_USED = (DICT_ENTRIES < 4096) ? DICT_ENTRIES : 4096;
  localparam int unsigned HT_AW = $clog2(DICT_USED) + 1;
  localparam int unsigned DA_W = $clog2(DICT_USED);
  localparam int unsigned DE_W = lz78_pkg::ENTRY_W + HT_AW;
  localparam int unsigned PW = lz78_pkg::PHRASE_W;
  localparam int unsigned SW = lz78_pkg::SYM_W;
  localparam int unsigned NW = lz78_pkg::NFI_W;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_HASH    = 6'b000100,
    ST_CHKSLOT = 6'b001000,
    ST_CHKENT  = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [SW-1:0]     sym_q, sym_d;
  logic              fin_q, fin_d;
  logic [PW-1:0]     prefix_q, prefix_d;
  logic [NW-1:0]     nfi_q, nfi_d;
  logic [PW-1:0]     limit_q;
  logic [HT_AW-1:0]  probe_q, probe_d;
  logic [PW-1:0]     cand_q, cand_d;
  logic              hit_q, hit_d;

  logic              out_vld_q, out_vld_d;
  logic [PW-1:0]     out_idx_q, out_idx_d;
  logic [SW-1:0]     out_sym_q, out_sym_d;
  logic              out_has_q, out_has_d;
  logic              out_eom_q, out_eom_d;

  logic              ht_rd, ht_wr, ht_busy;
  logic [HT_AW-1:0]  ht_addr;
  logic [PW-1:0]     ht_rdata;
  logic              dict_rd, dict_wr;
  logic [DA_W-1:0]   dict_addr;
  logic [DE_W-1:0]   dict_rdata;

  logic [31:0]       hash_prod;
  logic [HT_AW-1:0]  hash_addr;
  logic [HT_AW-1:0]  probe_nx;
  logic              slot_valid;
  logic              may_insert;
  logic              need_out;
  logic              out_free;

  lz78_hash_table #(
    .ADDR_W (HT_AW)
  ) u_hash_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (ht_rd),
    .wr_en_i (ht_wr),
    .addr_i  (ht_addr),
    .wdata_i (nfi_q[PW-1:0]),
    .rdata_o (ht_rdata),
    .busy_o  (ht_busy)
  );

  lz78_dict_mem #(
    .ADDR_W (DA_W),
    .DATA_W (DE_W)
  ) u_dict_mem (
    .clk_i   (clk_i),
    .rd_en_i (dict_rd),
    .wr_en_i (dict_wr),
    .addr_i  (dict_addr),
    .wdata_i ({prefix_q, sym_q, probe_q}),
    .rdata_o (dict_rdata)
  );

  assign hash_prod  = 32'({prefix_q, sym_q}) * lz78_pkg::HASH_MUL;
  assign hash_addr  = hash_prod[31 -: HT_AW];
  assign probe_nx   = probe_q + HT_AW'(1);
  assign slot_valid = (ht_rdata != '0) && ({1'b0, ht_rdata} < nfi_q);
  assign may_insert = (nfi_q <= {1'b0, limit_q}) && (32'(nfi_q) < DICT_ENTRIES) &&
                      (32'(nfi_q) <= lz78_pkg::MAX_INDEX);
  assign need_out   = !hit_q || fin_q;
  assign out_free   = !out_vld_q || tok_o.ready;

  assign req_i.ready         = (state_q == ST_IDLE);
  assign tok_o.valid          = out_vld_q;
  assign tok_o.phrase_index   = out_idx_q;
  assign tok_o.next_symbol    = out_sym_q;
  assign tok_o.has_symbol     = out_has_q;
  assign tok_o.end_of_message = out_eom_q;

  always_comb begin
    state_d   = state_q;
    sym_d     = sym_q;
    fin_d     = fin_q;
    prefix_d  = prefix_q;
    nfi_d     = nfi_q;
    probe_d   = probe_q;
    cand_d    = cand_q;
    hit_d     = hit_q;
    out_vld_d = out_vld_q && !tok_o.ready;
    out_idx_d = out_idx_q;
    out_sym_d = out_sym_q;
    out_has_d = out_has_q;
    out_eom_d = out_eom_q;
    ht_rd     = 1'b0;
    ht_wr     = 1'b0;
    ht_addr   = probe_q;
    dict_rd   = 1'b0;
    dict_wr   = 1'b0;
    dict_addr = DA_W'(cand_q);

    unique case (state_q)
      ST_CLEAR: begin
        if (!ht_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          sym_d   = req_i.symbol_byte;
          fin_d   = req_i.is_final;
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        ht_rd   = 1'b1;
        ht_addr = hash_addr;
        probe_d = hash_addr;
        state_d = ST_CHKSLOT;
      end
      ST_CHKSLOT: begin
        if (slot_valid) begin
          cand_d    = ht_rdata;
          dict_rd   = 1'b1;
          dict_addr = DA_W'(ht_rdata);
          state_d   = ST_CHKENT;
        end else begin
          hit_d   = 1'b0;
          state_d = ST_EMIT;
        end
      end
      ST_CHKENT: begin
        if (dict_rdata[HT_AW-1:0] != probe_q) begin
          hit_d   = 1'b0;
          state_d = ST_EMIT;
        end else if (dict_rdata[DE_W-1:HT_AW] == {prefix_q, sym_q}) begin
          hit_d   = 1'b1;
          state_d = ST_EMIT;
        end else begin
          probe_d = probe_nx;
          ht_rd   = 1'b1;
          ht_addr = probe_nx;
          state_d = ST_CHKSLOT;
        end
      end
      ST_EMIT: begin
        if (!need_out || out_free) begin
          if (hit_q) begin
            prefix_d = cand_q;
            if (fin_q) begin
              out_vld_d = 1'b1;
              out_idx_d = cand_q;
              out_sym_d = '0;
              out_has_d = 1'b0;
              out_eom_d = 1'b1;
            end
          end else begin
            out_vld_d = 1'b1;
            out_idx_d = prefix_q;
            out_sym_d = sym_q;
            out_has_d = 1'b1;
            out_eom_d = fin_q;
            if (may_insert) begin
              ht_wr     = 1'b1;
              dict_wr   = 1'b1;
              dict_addr = DA_W'(nfi_q[PW-1:0]);
              nfi_d     = nfi_q + NW'(1);
            end
            prefix_d = '0;
          end
          if (fin_q) begin
            prefix_d = '0;
            nfi_d    = NW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      prefix_q  <= '0;
      nfi_q     <= NW'(1);
      limit_q   <= lz78_pkg::LIMIT_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      prefix_q  <= prefix_d;
      nfi_q     <= nfi_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    fin_q     <= fin_d;
    probe_q   <= probe_d;
    cand_q    <= cand_d;
    hit_q     <= hit_d;
    out_idx_q <= out_idx_d;
    out_sym_q <= out_sym_d;
    out_has_q <= out_has_d;
    out_eom_q <= out_eom_d;
  end

endmodule

`default_nettype wire

@@ hdl/lz78_hash_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lz78_hash_table #(
  parameter int unsigned ADDR_W = 13
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            rd_en_i,
  input  wire logic                            wr_en_i,
  input  wire logic [ADDR_W-1:0]               addr_i,
  input  wire logic [lz78_pkg::PHRASE_W-1:0]   wdata_i,
  output logic      [lz78_pkg::PHRASE_W-1:0]   rdata_o,
  output logic                                 busy_o
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [lz78_pkg::PHRASE_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]             clr_addr_q;
  logic                          clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == {ADDR_W{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_o <= mem[addr_i];
    end
  end

  assign busy_o = clr_busy_q;

endmodule

`default_nettype wire

@@ hdl/lz78_dict_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lz78_dict_mem #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = lz78_pkg::ENTRY_W
) (
  input  wire logic                           clk_i,
  input  wire logic                           rd_en_i,
  input  wire logic                           wr_en_i,
  input  wire logic [ADDR_W-1:0]              addr_i,
  input  wire logic [DATA_W-1:0]              wdata_i,
  output logic      [DATA_W-1:0]              rdata_o
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

@@ test/lz78_encoder_tb.sv @@
`timescale 1ns / 1ps

typedef struct packed {
  logic [lz78_pkg::PHRASE_W-1:0] phrase_index;
  logic [lz78_pkg::SYM_W-1:0]    next_symbol;
  logic                          has_symbol;
  logic                          end_of_message;
} lz78_token_t;

class lz78_scoreboard;
  int unsigned phrase_of [bit [lz78_pkg::PHRASE_W+lz78_pkg::SYM_W-1:0]];
  logic [lz78_pkg::PHRASE_W-1:0] cur_prefix;
  logic [lz78_pkg::NFI_W-1:0]    next_free;
  logic [lz78_pkg::PHRASE_W-1:0] limit;
  lz78_token_t                   token_q[$];
  int                            errors;

  function new();
    cur_prefix = '0;
    next_free  = 1;
    limit      = lz78_pkg::LIMIT_RESET;
    errors     = 0;
  endfunction

  function void set_limit(logic [lz78_pkg::PHRASE_W-1:0] value);
    limit = value;
  endfunction

  function int pending();
    return token_q.size();
  endfunction

  function void add_expected(lz78_token_t tok);
    token_q.insert(token_q.size(), tok);
  endfunction

  // Encodes one accepted request and queues the token it causes, if any.
  function void note_request(logic [lz78_pkg::SYM_W-1:0] sym, logic fin);
    bit [lz78_pkg::PHRASE_W+lz78_pkg::SYM_W-1:0] key;
    lz78_token_t tok;
    key = {cur_prefix, sym};
    if (phrase_of.exists(key)) begin
      cur_prefix = lz78_pkg::PHRASE_W'(phrase_of[key]);
      if (fin) begin
        tok = '{cur_prefix, '0, 1'b0, 1'b1};
        add_expected(tok);
      end
    end else begin
      tok = '{cur_prefix, sym, 1'b1, fin};
      add_expected(tok);
      if (next_free <= {1'b0, limit} && next_free <= lz78_pkg::MAX_INDEX) begin
        phrase_of[key] = next_free;
        next_free++;
      end
      cur_prefix = '0;
    end
    if (fin) begin
      cur_prefix = '0;
      next_free  = 1;
      phrase_of.delete();
    end
  endfunction

  function void check_token(lz78_token_t got);
    lz78_token_t want;
    if (token_q.size() == 0) begin
      $error("unexpected token: phrase_index %0d next_symbol %0d", got.phrase_index,
             got.next_symbol);
      errors++;
      return;
    end
    want = token_q.pop_front();
    if (got.phrase_index !== want.phrase_index) begin
      $error("phrase_index: expected %0d, got %0d", want.phrase_index, got.phrase_index);
      errors++;
    end
    if (got.next_symbol !== want.next_symbol) begin
      $error("next_symbol: expected %0d, got %0d", want.next_symbol, got.next_symbol);
      errors++;
    end
    if (got.has_symbol !== want.has_symbol) begin
      $error("has_symbol: expected %0d, got %0d", want.has_symbol, got.has_symbol);
      errors++;
    end
    if (got.end_of_message !== want.end_of_message) begin
      $error("end_of_message: expected %0d, got %0d", want.end_of_message,
             got.end_of_message);
      errors++;
    end
  endfunction
endclass

module lz78_encoder_tb;
  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [lz78_pkg::PHRASE_W-1:0] cfg_wdata_i;

  lz78_in_if  req_if ();
  lz78_out_if tok_if ();

  lz78_scoreboard sb;
  int send_idle_pct;
  int rx_stall_pct;
  int items_sent;
  logic rx_hold;

  lz78_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .tok_o       (tok_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #40_000_000;
    $display("lz78_encoder_tb failed");
    $finish;
  end

  always @(posedge clk_i) begin : token_side
    lz78_token_t got;
    if (rst_ni === 1'b1 && tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
      got = '{tok_if.phrase_index, tok_if.next_symbol, tok_if.has_symbol,
              tok_if.end_of_message};
      sb.check_token(got);
    end
    tok_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic send_byte(logic [lz78_pkg::SYM_W-1:0] sym, logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.symbol_byte <= sym;
    req_if.is_final    <= fin;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(sym, fin);
    items_sent++;
  endtask

  // Lets every outstanding token drain and the block settle before returning.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0 || req_if.ready !== 1'b1) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [lz78_pkg::PHRASE_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(value);
  endtask

  task automatic hold_receiver(int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  task automatic send_random_message();
    logic [lz78_pkg::SYM_W-1:0] alphabet [6];
    logic [lz78_pkg::SYM_W-1:0] sym;
    bit noise;
    int n_sym;
    int len;
    int pick;
    noise = ($urandom_range(0, 9) == 0);
    n_sym = $urandom_range(1, 6);
    foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 19);
    if (pick == 0) len = $urandom_range(100, 200);
    else if (pick == 1) len = 1;
    else len = $urandom_range(2, 24);
    for (int i = 0; i < len; i++) begin
      sym = noise ? 8'($urandom_range(0, 255)) : alphabet[$urandom_range(0, n_sym - 1)];
      send_byte(sym, i == len - 1);
    end
  endtask

  task automatic random_limit();
    case ($urandom_range(0, 4))
      0: set_limit('0);
      1: set_limit(12'd1);
      2: set_limit(12'($urandom_range(2, 15)));
      3: set_limit(12'($urandom_range(16, 4094)));
      default: set_limit(lz78_pkg::LIMIT_RESET);
    endcase
  endtask

  initial begin
    int target;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.symbol_byte = '0;
    req_if.is_final    = 1'b0;
    tok_if.ready       = 1'b0;
    rx_hold            = 1'b0;
    send_idle_pct      = 0;
    rx_stall_pct       = 0;
    items_sent         = 0;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_byte("A", 1'b0);
    send_byte("A", 1'b0);
    send_byte("A", 1'b0);
    send_byte("A", 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b1);
    set_limit('0);
    send_byte("B", 1'b0);
    send_byte("B", 1'b0);
    send_byte("B", 1'b1);
    set_limit(12'd1);
    for (int i = 0; i < 6; i++) send_byte(i[0] ? "B" : "A", i == 5);
    set_limit(lz78_pkg::LIMIT_RESET);
    send_byte("C", 1'b0);
    send_byte("C", 1'b0);
    // The limit is changed while a match is still open in the middle of a message.
    set_limit(12'd2);
    send_byte("C", 1'b0);
    send_byte("C", 1'b0);
    send_byte("C", 1'b1);
    set_limit(lz78_pkg::LIMIT_RESET);

    fork
      hold_receiver(300);
      for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)), i == 39);
    join

    target = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 78; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 78; end
        default: begin send_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      target += 90;
      while (items_sent < target) begin
        if ($urandom_range(0, 3) == 0) random_limit();
        send_random_message();
      end
    end

    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("lz78_encoder_tb passed");
    end else begin
      $display("lz78_encoder_tb failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
hdl/lz78_pkg.sv
hdl/lz78_if.sv
hdl/lz78_hash_table.sv
hdl/lz78_dict_mem.sv
hdl/lz78_encoder.sv
test/lz78_encoder_tb.sv
